@@ hw/rtl/m2ad_pkg.sv @@
// Shared types and constants for the masked 2x2 average downsampler.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package m2ad_pkg;

   localparam int CHAN_W        = 16;
   localparam int NUM_CHAN      = 3;
   localparam int PAIR_SUM_W    = CHAN_W + 1;
   localparam int BLOCK_SUM_W   = CHAN_W + 2;
   localparam int PAIR_CNT_W    = 2;
   localparam int BLOCK_CNT_W   = 3;
   localparam int STORE_W       = NUM_CHAN * PAIR_SUM_W + PAIR_CNT_W;

   localparam int MAX_WIDTH_DEF = 4096;

   // Configuration port.
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int SRC_WIDTH_W   = 13;
   localparam int SRC_HEIGHT_W  = 16;
   localparam logic [CSR_IDX_W-1:0]    CSR_SOURCE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0]    CSR_SOURCE_HEIGHT = 1'd1;
   localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RESET   = 13'd4096;
   localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RESET  = 16'd2048;

   // Division by three: floor(x * RECIP3 / 2^RECIP3_SHIFT) equals x / 3 for x below 2^19.
   localparam int RECIP3_W     = 18;
   localparam int RECIP3_SHIFT = 19;
   localparam logic [RECIP3_W-1:0] RECIP3 = 18'd174763;

   typedef struct packed {
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] red_in;
      logic              pixel_valid;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue_avg;
      logic [CHAN_W-1:0] green_avg;
      logic [CHAN_W-1:0] red_avg;
      logic              out_valid;
      logic              row_end;
      logic              frame_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;        // a request beat is accepted this cycle
      logic store_pair;  // write the pair sums of a top row to the line store
      logic start_block; // capture the bottom pair and read the top pair
      logic combine;     // add the top pair to the bottom pair
      logic scale;       // divide the block sums by the valid count
      logic emit;        // load the result into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic col_odd;
      logic row_odd;
      logic pair_in_range;
      logic row_in_range;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/m2ad_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the line store of the downsampler.
`default_nettype none

module m2ad_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              write_en,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic              read_en,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/m2ad_ctrl.sv @@
// Controller state machine of the downsampler.
// Depends on m2ad_pkg; drives the datapath through ctrl_cmd_type commands.
`default_nettype none

module m2ad_ctrl
   import m2ad_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire dp_status_type status,
   output logic               req_stall,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.col_odd && status.pair_in_range) begin
                  if (!status.row_odd) begin
                     cmd.store_pair = 1'b1;
                  end else if (status.row_in_range) begin
                     cmd.start_block = 1'b1;
                     state_in        = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.combine = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/m2ad_datapath.sv @@
// Datapath of the downsampler: size registers, position counters, pair sums,
// line store, block sums, division by the valid count and output register.
// Depends on m2ad_pkg and m2ad_ram.
`default_nettype none

module m2ad_datapath
   import m2ad_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire req_payload_type       req_payload,
   input  wire logic                  rsp_stall,
   input  wire ctrl_cmd_type          cmd,
   output dp_status_type              status,
   output logic                       rsp_valid,
   output rsp_payload_type            rsp_payload
);

   localparam int CW     = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
   localparam int AW     = CW - 1;
   localparam int DEPTH  = MAX_WIDTH / 2;
   localparam int EW     = $clog2(MAX_WIDTH + 1);
   localparam int WW     = (EW > SRC_WIDTH_W) ? EW : SRC_WIDTH_W;
   localparam int PROD_W = BLOCK_SUM_W + 1 + RECIP3_W;

   // Size registers.
   logic [SRC_WIDTH_W-1:0]  width_ff, width_in;
   logic [SRC_HEIGHT_W-1:0] height_ff, height_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  width_in  = csr_wdata[SRC_WIDTH_W-1:0];
            CSR_SOURCE_HEIGHT: height_in = csr_wdata[SRC_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes and position decode.
   logic [WW-1:0]           width_ext, eff_width, pairs, pair_ext, col_ext;
   logic [WW:0]             col_next;
   logic [SRC_HEIGHT_W-1:0] eff_height, out_rows, row_half;
   logic [SRC_HEIGHT_W:0]   row_next;
   logic                    col_last, row_last, pair_last;

   logic [CW-1:0]           col_ff, col_in;
   logic [SRC_HEIGHT_W-1:0] row_ff, row_in;

   always_comb begin
      width_ext = WW'(width_ff);
      if (width_ext < WW'(2)) begin
         eff_width = WW'(2);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      eff_height = (height_ff < SRC_HEIGHT_W'(2)) ? SRC_HEIGHT_W'(2) : height_ff;
      pairs      = eff_width >> 1;
      out_rows   = eff_height >> 1;
      col_ext    = WW'(col_ff);
      pair_ext   = WW'(col_ff >> 1);
      row_half   = row_ff >> 1;
      col_next   = {1'b0, col_ext} + (WW + 1)'(1);
      row_next   = {1'b0, row_ff} + (SRC_HEIGHT_W + 1)'(1);
      col_last   = col_next >= {1'b0, eff_width};
      row_last   = row_next >= {1'b0, eff_height};
      pair_last  = pair_ext == (pairs - WW'(1));

      status.col_odd       = col_ff[0];
      status.row_odd       = row_ff[0];
      status.pair_in_range = pair_ext < pairs;
      status.row_in_range  = row_half < out_rows;
      status.out_free      = !rsp_valid || !rsp_stall;

      col_in = col_ff;
      row_in = row_ff;
      if (cmd.take) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_next[SRC_HEIGHT_W-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   // Left pixel of the current pair and the masked pair sums.
   logic [NUM_CHAN-1:0][CHAN_W-1:0]     cur_chan;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]     left_chan_ff, left_chan_in;
   logic                                left_valid_ff, left_valid_in;
   logic [NUM_CHAN-1:0][PAIR_SUM_W-1:0] pair_sum;
   logic [PAIR_CNT_W-1:0]               pair_cnt;
   logic [STORE_W-1:0]                  store_wdata, store_rdata;

   always_comb begin
      cur_chan[0] = req_payload.blue_in;
      cur_chan[1] = req_payload.green_in;
      cur_chan[2] = req_payload.red_in;
      for (int k = 0; k < NUM_CHAN; k++) begin
         pair_sum[k] = (left_valid_ff ? PAIR_SUM_W'(left_chan_ff[k]) : '0)
                     + (req_payload.pixel_valid ? PAIR_SUM_W'(cur_chan[k]) : '0);
      end
      pair_cnt = PAIR_CNT_W'(left_valid_ff) + PAIR_CNT_W'(req_payload.pixel_valid);

      store_wdata[PAIR_CNT_W-1:0] = pair_cnt;
      for (int k = 0; k < NUM_CHAN; k++) begin
         store_wdata[PAIR_CNT_W + k*PAIR_SUM_W +: PAIR_SUM_W] = pair_sum[k];
      end

      left_chan_in  = left_chan_ff;
      left_valid_in = left_valid_ff;
      if (cmd.take && !col_ff[0]) begin
         left_chan_in  = cur_chan;
         left_valid_in = req_payload.pixel_valid;
      end
   end

   m2ad_ram #(
      .WIDTH  (STORE_W),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_line_store (
      .clock      (clock),
      .write_en   (cmd.store_pair),
      .write_addr (col_ff[CW-1:1]),
      .write_data (store_wdata),
      .read_en    (cmd.start_block),
      .read_addr  (col_ff[CW-1:1]),
      .read_data  (store_rdata)
   );

   // Block pipeline registers.
   logic [NUM_CHAN-1:0][PAIR_SUM_W-1:0]  bot_sum_ff, bot_sum_in;
   logic [PAIR_CNT_W-1:0]                bot_cnt_ff, bot_cnt_in;
   logic                                 row_end_ff, row_end_in;
   logic                                 frame_end_ff, frame_end_in;
   logic [NUM_CHAN-1:0][BLOCK_SUM_W-1:0] blk_sum_ff, blk_sum_in;
   logic [BLOCK_CNT_W-1:0]               blk_cnt_ff, blk_cnt_in;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]      quot_ff, quot_in;
   logic                                 quot_valid_ff, quot_valid_in;
   logic [NUM_CHAN-1:0][BLOCK_SUM_W:0]   rounded;
   logic [NUM_CHAN-1:0][PROD_W-1:0]      prod;
   rsp_payload_type                      rsp_ff, rsp_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      bot_sum_in   = bot_sum_ff;
      bot_cnt_in   = bot_cnt_ff;
      row_end_in   = row_end_ff;
      frame_end_in = frame_end_ff;
      if (cmd.start_block) begin
         bot_sum_in   = pair_sum;
         bot_cnt_in   = pair_cnt;
         row_end_in   = pair_last;
         frame_end_in = pair_last && (row_half == (out_rows - SRC_HEIGHT_W'(1)));
      end

      blk_sum_in = blk_sum_ff;
      blk_cnt_in = blk_cnt_ff;
      if (cmd.combine) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            blk_sum_in[k] = BLOCK_SUM_W'(bot_sum_ff[k])
               + BLOCK_SUM_W'(store_rdata[PAIR_CNT_W + k*PAIR_SUM_W +: PAIR_SUM_W]);
         end
         blk_cnt_in = BLOCK_CNT_W'(bot_cnt_ff) + BLOCK_CNT_W'(store_rdata[PAIR_CNT_W-1:0]);
      end

      // Round to nearest: add half the count, then divide by the count.
      quot_in       = quot_ff;
      quot_valid_in = quot_valid_ff;
      for (int k = 0; k < NUM_CHAN; k++) begin
         rounded[k] = (BLOCK_SUM_W + 1)'(blk_sum_ff[k])
                    + (BLOCK_SUM_W + 1)'(blk_cnt_ff >> 1);
         prod[k]    = PROD_W'(rounded[k]) * PROD_W'(RECIP3);
      end
      if (cmd.scale) begin
         quot_valid_in = blk_cnt_ff != '0;
         for (int k = 0; k < NUM_CHAN; k++) begin
            case (blk_cnt_ff)
               3'd1:    quot_in[k] = rounded[k][CHAN_W-1:0];
               3'd2:    quot_in[k] = rounded[k][CHAN_W:1];
               3'd3:    quot_in[k] = prod[k][RECIP3_SHIFT +: CHAN_W];
               3'd4:    quot_in[k] = rounded[k][CHAN_W+1:2];
               default: quot_in[k] = '0;
            endcase
         end
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in.blue_avg  = quot_ff[0];
         rsp_in.green_avg = quot_ff[1];
         rsp_in.red_avg   = quot_ff[2];
         rsp_in.out_valid = quot_valid_ff;
         rsp_in.row_end   = row_end_ff;
         rsp_in.frame_end = frame_end_ff;
         rsp_valid_in     = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= SRC_WIDTH_RESET;
         height_ff     <= SRC_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         left_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_valid_ff <= left_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_chan_ff  <= left_chan_in;
      bot_sum_ff    <= bot_sum_in;
      bot_cnt_ff    <= bot_cnt_in;
      row_end_ff    <= row_end_in;
      frame_end_ff  <= frame_end_in;
      blk_sum_ff    <= blk_sum_in;
      blk_cnt_ff    <= blk_cnt_in;
      quot_ff       <= quot_in;
      quot_valid_ff <= quot_valid_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/masked_2x2_average_downsample.sv @@
// Masked 2x2 average downsampler, top level: controller plus datapath.
// Pixels of even columns and of even rows are taken in the idle state; a pixel that
// completes a block goes through accept with line store read, block sum, divide and output
// load, plus any wait for the output register, and new requests stall until the output load.
// Synchronous active-high reset clears the counters, the left valid flag, the output valid and
// the size registers (4096 by 2048); the line store is not cleared.
`default_nettype none

module masked_2x2_average_downsample
   import m2ad_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_payload
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   m2ad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   m2ad_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .rsp_stall    (rsp_stall),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire
